// ----- rtl/core/bcd_pkg.sv -----
`default_nettype none

package bcd_pkg;

   localparam int MAGNITUDE_WIDTH     = 64;
   localparam int DIGIT_WIDTH         = 4;
   localparam int VALUE_BITS_DEFAULT  = 64;
   localparam int DIGIT_COUNT_DEFAULT = 20;

   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ZERO   = 4'd0;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_FIVE   = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJUST = 4'd3;

endpackage

`default_nettype wire

// ----- rtl/core/bcd_if.sv -----
`default_nettype none

interface bcd_req_if import bcd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [MAGNITUDE_WIDTH-1:0] magnitude;
   logic                       negative;

   modport source (output valid, output magnitude, output negative, input ready);
   modport sink (input valid, input magnitude, input negative, output ready);
endinterface

interface bcd_rsp_if import bcd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [DIGIT_WIDTH-1:0] digit;
   logic                   is_negative;
   logic                   last_digit;

   modport source (output valid, output digit, output is_negative, output last_digit,
                   input ready);
   modport sink (input valid, input digit, input is_negative, input last_digit,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/core/binary_to_bcd_converter_core.sv -----
// order: the magnitude is converted bit by bit, suppressed leading zeros are dropped, then
// one digit item per cycle is emitted while the result side takes them
// the single shift-and-correct unit runs once per magnitude bit, then the digit emit loop runs;
// a new request is taken only in idle, after the last digit item of the previous one is registered
// reset: synchronous active-high reset returns the sequencer to idle and drops rsp valid
`default_nettype none

module binary_to_bcd_converter_core import bcd_pkg::*; #(
   parameter int VALUE_BITS  = VALUE_BITS_DEFAULT,
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   bcd_req_if.sink     req_if,
   bcd_rsp_if.source   rsp_if
);

   localparam int CHAIN_WIDTH  = DIGIT_COUNT * DIGIT_WIDTH;
   localparam int BIT_CNT_W    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int REMAIN_W     = $clog2(DIGIT_COUNT + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [VALUE_BITS-1:0]   mag_ff;
   logic [CHAIN_WIDTH-1:0]  chain_ff;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff;
   logic [REMAIN_W-1:0]     remain_ff;
   logic                    sign_ff;
   logic                    rsp_valid_ff;
   logic [DIGIT_WIDTH-1:0]  rsp_digit_ff;
   logic                    rsp_neg_ff;
   logic                    rsp_last_ff;

   logic [CHAIN_WIDTH-1:0]  corrected;
   logic [CHAIN_WIDTH-1:0]  dabble_in;
   logic [CHAIN_WIDTH-1:0]  digit_shift_in;
   logic [DIGIT_WIDTH-1:0]  top_digit;
   logic                    out_free;

   // correct every digit of 5 or more, then shift one bit in
   always_comb begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (chain_ff[k*DIGIT_WIDTH +: DIGIT_WIDTH] >= DIGIT_FIVE) begin
            corrected[k*DIGIT_WIDTH +: DIGIT_WIDTH] =
               chain_ff[k*DIGIT_WIDTH +: DIGIT_WIDTH] + DIGIT_ADJUST;
         end else begin
            corrected[k*DIGIT_WIDTH +: DIGIT_WIDTH] = chain_ff[k*DIGIT_WIDTH +: DIGIT_WIDTH];
         end
      end
   end

   assign dabble_in      = {corrected[CHAIN_WIDTH-2:0], mag_ff[VALUE_BITS-1]};
   assign digit_shift_in = {chain_ff[CHAIN_WIDTH-DIGIT_WIDTH-1:0], DIGIT_ZERO};
   assign top_digit      = chain_ff[CHAIN_WIDTH-1 -: DIGIT_WIDTH];
   assign out_free       = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.digit       = rsp_digit_ff;
   assign rsp_if.is_negative = rsp_neg_ff;
   assign rsp_if.last_digit  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  mag_ff     <= req_if.magnitude[VALUE_BITS-1:0];
                  sign_ff    <= req_if.negative;
                  chain_ff   <= '0;
                  bit_cnt_ff <= BIT_CNT_W'(VALUE_BITS - 1);
                  remain_ff  <= REMAIN_W'(DIGIT_COUNT);
                  state_ff   <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               chain_ff   <= dabble_in;
               mag_ff     <= {mag_ff[VALUE_BITS-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff - 1'b1;
               if (bit_cnt_ff == '0) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // drop leading zeros, keep at least one digit
               if (top_digit == DIGIT_ZERO && remain_ff > REMAIN_W'(1)) begin
                  chain_ff  <= digit_shift_in;
                  remain_ff <= remain_ff - 1'b1;
               end else begin
                  if (top_digit == DIGIT_ZERO) begin
                     sign_ff <= 1'b0;
                  end
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_digit_ff <= top_digit;
                  rsp_neg_ff   <= sign_ff;
                  rsp_last_ff  <= (remain_ff == REMAIN_W'(1));
                  chain_ff     <= digit_shift_in;
                  remain_ff    <= remain_ff - 1'b1;
                  if (remain_ff == REMAIN_W'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- dv/tb_binary_to_bcd_converter_core.sv -----
`default_nettype none

module tb_binary_to_bcd_converter_core;
   import bcd_pkg::*;

   localparam int VALUE_BITS     = VALUE_BITS_DEFAULT;
   localparam int DIGIT_COUNT    = DIGIT_COUNT_DEFAULT;
   localparam int MAX_GAP        = 8;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 120;
   localparam int RANDOM_ITEMS   = 380;
   localparam int STEADY_ITEMS   = 40;

   typedef struct packed {
      logic [DIGIT_WIDTH-1:0] digit;
      logic                   is_negative;
      logic                   last_digit;
   } bcd_digit_type;

   logic clock;
   logic reset;

   bcd_req_if req_bus ();
   bcd_rsp_if rsp_bus ();

   bcd_digit_type pending_digits[$];
   int         error_count;
   int         idle_cycles;
   bit         steady_flow;

   binary_to_bcd_converter_core #(
      .VALUE_BITS  (VALUE_BITS),
      .DIGIT_COUNT (DIGIT_COUNT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // double dabble over the low VALUE_BITS bits, leading zeros dropped
   function automatic void predict_conversion(input logic [MAGNITUDE_WIDTH-1:0] value,
                                              input logic                       neg);
      logic [DIGIT_WIDTH-1:0] chain [DIGIT_COUNT];
      logic [DIGIT_WIDTH-1:0] d;
      logic                   carry;
      logic                   spill;
      int                     top;
      bcd_digit_type          item;
      for (int j = 0; j < DIGIT_COUNT; j++) begin
         chain[j] = DIGIT_ZERO;
      end
      for (int b = VALUE_BITS - 1; b >= 0; b--) begin
         carry = value[b];
         for (int j = DIGIT_COUNT - 1; j >= 0; j--) begin
            d = chain[j];
            if (d >= DIGIT_FIVE) begin
               d = d + DIGIT_ADJUST;
            end
            spill    = d[DIGIT_WIDTH-1];
            chain[j] = {d[DIGIT_WIDTH-2:0], carry};
            carry    = spill;
         end
      end
      top = DIGIT_COUNT;
      for (int j = DIGIT_COUNT - 1; j >= 0; j--) begin
         if (chain[j] != DIGIT_ZERO) begin
            top = j;
         end
      end
      if (top == DIGIT_COUNT) begin
         item.digit       = DIGIT_ZERO;
         item.is_negative = 1'b0;
         item.last_digit  = 1'b1;
         pending_digits.push_back(item);
      end else begin
         for (int j = top; j < DIGIT_COUNT; j++) begin
            item.digit       = chain[j];
            item.is_negative = neg;
            item.last_digit  = (j == DIGIT_COUNT - 1);
            pending_digits.push_back(item);
         end
      end
   endfunction

   task automatic send_value(input logic [MAGNITUDE_WIDTH-1:0] value, input logic neg);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.magnitude <= value;
      req_bus.negative  <= neg;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_conversion(value, neg);
   endtask

   function automatic logic [MAGNITUDE_WIDTH-1:0] random_value(input int width);
      logic [MAGNITUDE_WIDTH-1:0] value;
      value = {$urandom, $urandom};
      if (width <= 0) begin
         return '0;
      end
      return value >> (MAGNITUDE_WIDTH - width);
   endfunction

   task automatic test_zero_and_sign();
      send_value(64'd0, 1'b0);
      send_value(64'd0, 1'b1);
      send_value(64'd1, 1'b1);
      send_value(64'd1, 1'b0);
      send_value(64'd9, 1'b1);
   endtask

   task automatic test_decade_edges();
      send_value(64'd10, 1'b0);
      send_value(64'd99, 1'b1);
      send_value(64'd100, 1'b0);
      send_value(64'd5, 1'b0);
      send_value(64'd9999999999999999999, 1'b1);
      send_value(64'd10000000000000000000, 1'b0);
   endtask

   task automatic test_bit_extremes();
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_value(64'h8000_0000_0000_0000, 1'b0);
      send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      send_value(64'h5555_5555_5555_5555, 1'b0);
      send_value(64'h0000_0000_FFFF_FFFF, 1'b1);
      send_value(64'h0000_0001_0000_0000, 1'b0);
   endtask

   task automatic test_steady_stream();
      steady_flow = 1'b1;
      for (int n = 0; n < STEADY_ITEMS; n++) begin
         send_value(random_value($urandom_range(0, MAGNITUDE_WIDTH)), 1'($urandom));
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_random_values();
      int width;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // one in three at full width, the rest spread over random widths up to full width
         width = ($urandom_range(0, 2) == 0) ? MAGNITUDE_WIDTH
                                            : $urandom_range(0, MAGNITUDE_WIDTH);
         send_value(random_value(width), 1'($urandom));
      end
   endtask

   // result side: random stall per item, none during the steady stream
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      bcd_digit_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_digits.size() == 0) begin
            $error("unexpected digit item: digit %0d", rsp_bus.digit);
            error_count++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_bus.digit !== want.digit) begin
               $error("digit: expected %0d, got %0d", want.digit, rsp_bus.digit);
               error_count++;
            end
            if (rsp_bus.is_negative !== want.is_negative) begin
               $error("is_negative: expected %0b, got %0b", want.is_negative,
                      rsp_bus.is_negative);
               error_count++;
            end
            if (rsp_bus.last_digit !== want.last_digit) begin
               $error("last_digit: expected %0b, got %0b", want.last_digit,
                      rsp_bus.last_digit);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_binary_to_bcd_converter_core NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      steady_flow        = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.magnitude  <= '0;
      req_bus.negative   <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_and_sign();
      test_decade_edges();
      test_bit_extremes();
      test_steady_stream();
      test_random_values();
      req_bus.valid <= 1'b0;

      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_binary_to_bcd_converter_core OK");
      end else begin
         $display("tb_binary_to_bcd_converter_core NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- binary_to_bcd_converter_core.f -----
rtl/core/bcd_pkg.sv
rtl/core/bcd_if.sv
rtl/core/binary_to_bcd_converter_core.sv
dv/tb_binary_to_bcd_converter_core.sv
